// ===== design/dhoat_pkg.sv =====
// shared types, widths and codes of the double hashing table
package dhoat_pkg;

    localparam int KEY_W         = 31;
    localparam int REQ_W         = 2;
    localparam int STAT_W        = 2;
    localparam int CFG_W         = 7;
    localparam int MARK_W        = 2;
    localparam int ENTRY_W       = KEY_W + MARK_W;
    localparam int MAX_SLOTS_DEF = 64;
    localparam int DIV_STEPS     = (KEY_W + 1) / 2;
    localparam int DVD_W         = 2 * DIV_STEPS;
    localparam int DCNT_W        = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(7);
    localparam logic [CFG_W-1:0] M_MIN          = CFG_W'(2);

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    localparam logic [MARK_W-1:0] MARK_EMPTY    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_OCCUPIED = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED  = 2'd2;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
        logic [CFG_W-1:0] div_a;
        logic [CFG_W-1:0] div_b;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem_a;
        logic [CFG_W-1:0] rem_b;
    } mod_res_t;

endpackage

// ===== design/dhoat_ram.sv =====
// generic single write port, single read port ram with registered read
module dhoat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/dhoat_mod.sv =====
// two remainders of one key by two small divisors, two bits per cycle
module dhoat_mod
    import dhoat_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_res_t res
);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [CFG_W-1:0]  rem_a_reg, rem_a_next;
    logic [CFG_W-1:0]  rem_b_reg, rem_b_next;
    logic [CFG_W-1:0]  da_reg, da_next;
    logic [CFG_W-1:0]  db_reg, db_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CFG_W-1:0]  ra_mid, rb_mid;

    function automatic logic [CFG_W-1:0] rem_step(
        input logic [CFG_W-1:0] r,
        input logic             b,
        input logic [CFG_W-1:0] d
    );
        logic [CFG_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
        begin
            t = t - {1'b0, d};
        end
        return t[CFG_W-1:0];
    endfunction

    always_comb
    begin
        dvd_next   = dvd_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        da_next    = da_reg;
        db_next    = db_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        ra_mid     = rem_step(rem_a_reg, dvd_reg[DVD_W-1], da_reg);
        rb_mid     = rem_step(rem_b_reg, dvd_reg[DVD_W-1], db_reg);
        if (req.start)
        begin
            dvd_next   = DVD_W'(req.key);
            rem_a_next = '0;
            rem_b_next = '0;
            da_next    = req.div_a;
            db_next    = req.div_b;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_a_next = rem_step(ra_mid, dvd_reg[DVD_W-2], da_reg);
            rem_b_next = rem_step(rb_mid, dvd_reg[DVD_W-2], db_reg);
            dvd_next   = {dvd_reg[DVD_W-3:0], 2'b00};
            cnt_next   = cnt_reg + DCNT_W'(1);
            if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
        da_reg    <= da_next;
        db_reg    <= db_next;
    end

    assign res.done  = done_reg;
    assign res.rem_a = rem_a_reg;
    assign res.rem_b = rem_b_reg;

endmodule

// ===== design/double_hash_open_address_table_core.sv =====
// open addressing hash table with double hashing, entries kept in one ram
// a request computes the key remainders, then per probe reads the ram and checks the entry,
// then stages the output word; an unused request code goes straight to staging the word
// throughput: one request at a time; the next one is taken once the word is staged
// reset: a clear sweep writes every entry empty, with in_stall high
// table_size resets to 7
module double_hash_open_address_table_core
    import dhoat_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_W-1:0]             cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [REQ_W-1:0]             req_type,
    input  logic [KEY_W-1:0]             key,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [STAT_W-1:0]            status,
    output logic [$clog2(MAX_SLOTS)-1:0] slot
);

    localparam int AW = $clog2(MAX_SLOTS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_EV    = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CFG_W-1:0]  cfg_reg;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [AW-1:0]     slot_reg, slot_next;

    logic [REQ_W-1:0]  req_reg, req_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [CFG_W-1:0]  m_reg, m_next;
    logic [CFG_W-1:0]  cur_reg, cur_next;
    logic [CFG_W-1:0]  stride_reg, stride_next;
    logic [CFG_W-1:0]  cnt_reg, cnt_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;
    logic [CFG_W-1:0]  res_slot_reg, res_slot_next;

    logic [CFG_W-1:0]  m_use;
    logic              accept;
    logic              out_free;
    mod_req_t          mreq;
    mod_res_t          mres;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [MARK_W-1:0] rd_mark;
    logic [KEY_W-1:0]  rd_key;

    logic [CFG_W:0]    first;
    logic [CFG_W:0]    sum;
    logic              last;
    logic [AW+CFG_W-1:0] cur_wide;
    logic [AW+CFG_W-1:0] res_wide;
    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     res_addr;

    // size in use
    always_comb
    begin
        if (cfg_reg < M_MIN)
        begin
            m_use = M_MIN;
        end
        else if (int'(cfg_reg) > MAX_SLOTS)
        begin
            m_use = CFG_W'(MAX_SLOTS);
        end
        else
        begin
            m_use = cfg_reg;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign cur_wide = {{AW{1'b0}}, cur_reg};
    assign res_wide = {{AW{1'b0}}, res_slot_reg};
    assign cur_addr = cur_wide[AW-1:0];
    assign res_addr = res_wide[AW-1:0];

    assign mreq.start = accept && (req_type inside {REQ_INSERT, REQ_SEARCH, REQ_DELETE});
    assign mreq.key   = key;
    assign mreq.div_a = m_use;
    assign mreq.div_b = m_use - CFG_W'(1);

    dhoat_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .res   (mres)
    );

    assign rd_mark = ram_rdata[MARK_W-1:0];
    assign rd_key  = ram_rdata[MARK_W +: KEY_W];
    assign first   = {1'b0, mres.rem_a} + (CFG_W+1)'(1);
    assign sum     = {1'b0, cur_reg} + {1'b0, stride_reg};
    assign last    = (cnt_reg == (m_reg - CFG_W'(1)));
    assign ram_re  = (state_reg == S_RD);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        req_next       = req_reg;
        key_next       = key_reg;
        m_next         = m_reg;
        cur_next       = cur_reg;
        stride_next    = stride_reg;
        cnt_next       = cnt_reg;
        res_stat_next  = res_stat_reg;
        res_slot_next  = res_slot_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_addr;
        ram_wdata      = {key_reg, MARK_OCCUPIED};

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MAX_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next = req_type;
                    key_next = key;
                    m_next   = m_use;
                    if (mreq.start)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        res_stat_next = STAT_NOT_FOUND;
                        res_slot_next = '0;
                        state_next    = S_FIN;
                    end
                end
            end
            S_DIV:
            begin
                if (mres.done)
                begin
                    if (first == {1'b0, m_reg})
                    begin
                        cur_next = '0;
                    end
                    else
                    begin
                        cur_next = first[CFG_W-1:0];
                    end
                    stride_next = m_reg - CFG_W'(1) - mres.rem_b;
                    cnt_next    = '0;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                // advance to the next probe unless the walk ends below
                if (sum >= {1'b0, m_reg})
                begin
                    cur_next = CFG_W'(sum - {1'b0, m_reg});
                end
                else
                begin
                    cur_next = sum[CFG_W-1:0];
                end
                cnt_next   = cnt_reg + CFG_W'(1);
                state_next = S_RD;
                if (req_reg == REQ_INSERT)
                begin
                    if (rd_mark != MARK_OCCUPIED)
                    begin
                        ram_we        = 1'b1;
                        ram_wdata     = {key_reg, MARK_OCCUPIED};
                        res_stat_next = STAT_OK;
                        res_slot_next = cur_reg;
                        state_next    = S_FIN;
                    end
                    else if (last)
                    begin
                        res_stat_next = STAT_FULL;
                        res_slot_next = '0;
                        state_next    = S_FIN;
                    end
                end
                else
                begin
                    if (rd_mark == MARK_EMPTY)
                    begin
                        res_stat_next = STAT_NOT_FOUND;
                        res_slot_next = '0;
                        state_next    = S_FIN;
                    end
                    else if (rd_mark == MARK_OCCUPIED && rd_key == key_reg)
                    begin
                        ram_we        = (req_reg == REQ_DELETE);
                        ram_wdata     = {rd_key, MARK_DELETED};
                        res_stat_next = STAT_OK;
                        res_slot_next = cur_reg;
                        state_next    = S_FIN;
                    end
                    else if (last)
                    begin
                        res_stat_next = STAT_NOT_FOUND;
                        res_slot_next = '0;
                        state_next    = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_stat_reg;
                    slot_next      = res_addr;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    dhoat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (cur_addr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            cfg_reg       <= TABLE_SIZE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        req_reg      <= req_next;
        key_reg      <= key_next;
        m_reg        <= m_next;
        cur_reg      <= cur_next;
        stride_reg   <= stride_next;
        cnt_reg      <= cnt_next;
        res_stat_reg <= res_stat_next;
        res_slot_reg <= res_slot_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;

endmodule

// ===== design/dhoat_checker.sv =====
// port level checks of the double hashing table, bound to the top level
module dhoat_checker
    import dhoat_pkg::*;
#(
    parameter int SLOT_W = 6
) (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [STAT_W-1:0] status,
    input logic [SLOT_W-1:0] slot
);

    // a failed request reports slot zero
    a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> slot == '0)
        else $error("nonzero slot on failed request");

    // one request at a time: input closes right after a request is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while one is in flight");

    // the request is registered before its word is staged in S_FIN, so no request finishes next cycle
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result word appeared too early");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot))
        else $error("stalled output word changed");

endmodule

bind double_hash_open_address_table_core dhoat_checker #(
    .SLOT_W ($bits(slot))
) u_dhoat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .slot      (slot)
);
